// ===== rtl/core/ccpg_pkg.sv =====
package ccpg_pkg;

    localparam int unsigned NUM_PIX = 8;

    // display mode codes: bit0 multicolour, bit1 bitmap, bit2 extended background
    localparam logic [2:0] MODE_STD_TEXT = 3'd0;
    localparam logic [2:0] MODE_MC_TEXT  = 3'd1;
    localparam logic [2:0] MODE_HIRES_BM = 3'd2;
    localparam logic [2:0] MODE_MC_BM    = 3'd3;
    localparam logic [2:0] MODE_ECM_TEXT = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DISPLAY_MODE = 3'd0;
    localparam logic [2:0] REG_BORDER_COLOR = 3'd1;
    localparam logic [2:0] REG_BG_COLOR_0   = 3'd2;
    localparam logic [2:0] REG_BG_COLOR_1   = 3'd3;
    localparam logic [2:0] REG_BG_COLOR_2   = 3'd4;
    localparam logic [2:0] REG_BG_COLOR_3   = 3'd5;

    localparam int unsigned PADDR_W = 5;

    typedef struct packed {
        logic [2:0]      display_mode;
        logic [3:0]      border_color;
        logic [3:0][3:0] bg_color;
    } cfg_t;

    typedef struct packed {
        logic       border;
        logic [7:0] char_code;
        logic [7:0] pattern;
        logic [3:0] color_nibble;
    } cell_t;

    typedef struct packed {
        logic [14:0] pixel_0;
        logic [14:0] pixel_1;
        logic [14:0] pixel_2;
        logic [14:0] pixel_3;
        logic [14:0] pixel_4;
        logic [14:0] pixel_5;
        logic [14:0] pixel_6;
        logic [14:0] pixel_7;
    } pix_t;

    localparam logic [15:0][23:0] PALETTE_888 = {
        24'ha4a7a2, 24'h5f53fe, 24'h59fe59, 24'h70746f,
        24'h424540, 24'hfe4a57, 24'h6a3304, 24'hb84104,
        24'hdff60a, 24'h211bae, 24'h1fd21e, 24'hb41ae2,
        24'h30e6c6, 24'hbe1a24, 24'hfdfefc, 24'h000000
    };

    // 8:8:8 to 5:5:5 by dropping the low three bits of each channel
    function automatic logic [14:0] to_rgb555(input logic [3:0] idx);
        logic [23:0] c;
        c = PALETTE_888[idx];
        return {c[23:19], c[15:11], c[7:3]};
    endfunction

endpackage

// ===== rtl/core/ccpg_regs.sv =====
module ccpg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccpg_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output ccpg_pkg::cfg_t                    cfg
);
    import ccpg_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_DISPLAY_MODE: cfg_next.display_mode = pwdata[2:0];
                REG_BORDER_COLOR: cfg_next.border_color = pwdata[3:0];
                REG_BG_COLOR_0:   cfg_next.bg_color[0]  = pwdata[3:0];
                REG_BG_COLOR_1:   cfg_next.bg_color[1]  = pwdata[3:0];
                REG_BG_COLOR_2:   cfg_next.bg_color[2]  = pwdata[3:0];
                REG_BG_COLOR_3:   cfg_next.bg_color[3]  = pwdata[3:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        case (reg_idx)
            REG_DISPLAY_MODE: prdata = {29'd0, cfg_reg.display_mode};
            REG_BORDER_COLOR: prdata = {28'd0, cfg_reg.border_color};
            REG_BG_COLOR_0:   prdata = {28'd0, cfg_reg.bg_color[0]};
            REG_BG_COLOR_1:   prdata = {28'd0, cfg_reg.bg_color[1]};
            REG_BG_COLOR_2:   prdata = {28'd0, cfg_reg.bg_color[2]};
            REG_BG_COLOR_3:   prdata = {28'd0, cfg_reg.bg_color[3]};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/ccpg_lane.sv =====
module ccpg_lane (
    input  ccpg_pkg::cfg_t  cfg,
    input  logic            border,
    input  logic [7:0]      char_code,
    input  logic [3:0]      color_nibble,
    input  logic            pix_bit,
    input  logic [1:0]      pix_pair,
    output logic [14:0]     pixel
);
    import ccpg_pkg::*;

    logic [3:0] idx;
    logic       black;

    always_comb
    begin
        idx   = 4'd0;
        black = 1'b0;
        if (border)
        begin
            idx = cfg.border_color;
        end
        else
        begin
            case (cfg.display_mode)
                MODE_STD_TEXT:
                    idx = pix_bit ? color_nibble : cfg.bg_color[0];
                MODE_MC_TEXT:
                begin
                    // multicolour only for cells whose colour nibble has bit 3 set
                    if (color_nibble[3])
                        idx = (pix_pair == 2'b11) ? {1'b0, color_nibble[2:0]}
                                                  : cfg.bg_color[pix_pair];
                    else
                        idx = pix_bit ? color_nibble : cfg.bg_color[0];
                end
                MODE_HIRES_BM:
                    idx = pix_bit ? char_code[7:4] : char_code[3:0];
                MODE_MC_BM:
                begin
                    case (pix_pair)
                        2'b00:   idx = cfg.bg_color[0];
                        2'b01:   idx = char_code[7:4];
                        2'b10:   idx = char_code[3:0];
                        default: idx = color_nibble;
                    endcase
                end
                MODE_ECM_TEXT:
                    idx = pix_bit ? color_nibble : cfg.bg_color[char_code[7:6]];
                default:
                    black = 1'b1;
            endcase
        end
    end

    assign pixel = black ? 15'd0 : to_rgb555(idx);

endmodule

// ===== rtl/core/character_cell_pixel_generator.sv =====
// Character cell pixel generator. One cell item (border flag, screen code,
// pattern byte, colour nibble) in, eight RGB555 pixels out, leftmost pixel
// from the pattern MSB. Throughput is one cell per clock when pix_ready does
// not stall the output. Each cell passes the input register and then the
// result register, between which eight identical pixel lanes pick a palette
// index and look it up. Mode and colour registers sit on the APB port at byte
// address 4*index and should only be changed while no cell is in flight.
module character_cell_pixel_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccpg_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          cell_valid,
    output logic                          cell_ready,
    input  ccpg_pkg::cell_t               cell_data,
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output ccpg_pkg::pix_t                pixels
);
    import ccpg_pkg::*;

    cfg_t                     cfg;
    cell_t                    cell_reg;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    pix_t                     pix_reg;
    logic                     pix_valid_reg;
    logic                     pix_valid_next;
    logic                     s2_free;
    logic                     s1_adv;
    logic [NUM_PIX-1:0][14:0] lane_pix;
    pix_t                     pix_next;

    ccpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s2_free    = !pix_valid_reg || pix_ready;
    assign s1_adv     = s1_valid_reg && s2_free;
    assign cell_ready = !s1_valid_reg || s2_free;

    assign s1_valid_next  = (cell_valid && cell_ready) || (s1_valid_reg && !s2_free);
    assign pix_valid_next = s1_adv || (pix_valid_reg && !pix_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_valid && cell_ready)
            cell_reg <= cell_data;
        if (s1_adv)
            pix_reg <= pix_next;
    end

    genvar p;
    generate
        for (p = 0; p < NUM_PIX; p++)
        begin : g_lane
            // pairs are two pixels wide, pair 7:6 leftmost
            ccpg_lane u_lane (
                .cfg          (cfg),
                .border       (cell_reg.border),
                .char_code    (cell_reg.char_code),
                .color_nibble (cell_reg.color_nibble),
                .pix_bit      (cell_reg.pattern[NUM_PIX-1-p]),
                .pix_pair     (cell_reg.pattern[(NUM_PIX-1-(p & ~1)) -: 2]),
                .pixel        (lane_pix[p])
            );
        end
    endgenerate

    assign pix_next = {lane_pix[0], lane_pix[1], lane_pix[2], lane_pix[3],
                       lane_pix[4], lane_pix[5], lane_pix[6], lane_pix[7]};

    assign pix_valid = pix_valid_reg;
    assign pixels    = pix_reg;

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && cell_ready) |=> s1_valid_reg)
        else $error("accepted item not held in input register");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> s1_valid_reg)
        else $error("stalled item dropped from input register");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> pix_valid_reg)
        else $error("item lost between input and result register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid_reg |-> cell_ready)
        else $error("input stalled while result register empty");
`endif

endmodule

// ===== tb/sv/tb_character_cell_pixel_generator.sv =====
module tb_character_cell_pixel_generator;

    import ccpg_pkg::*;

    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 2000;

    // display mode codes with no defined behaviour
    localparam logic [2:0] MODE_RSVD_5 = 3'd5;
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    // RGB555 of palette 0, 1 and 15
    localparam logic [14:0] BLACK      = 15'h0000;
    localparam logic [14:0] WHITE      = 15'h7fff;
    localparam logic [14:0] LIGHT_GREY = 15'h5294;

    typedef struct {
        cfg_t        k;
        cell_t       c;
        bit          known;
        logic [14:0] fill;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 cell_valid;
    logic                 cell_ready;
    cell_t                cell_data;
    logic                 pix_valid;
    logic                 pix_ready;
    pix_t                 pixels;

    pix_t                 pixels_due[$];
    row_t                 cell_table[$];
    int                   mismatches = 0;
    int                   stalled_cycles = 0;
    bit                   no_idle = 1'b0;
    pix_t                 head;
    int                   lane;

    character_cell_pixel_generator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pixels     (pixels)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [14:0] palette_rgb555(input logic [3:0] idx);
        logic [23:0] rgb;
        logic [23:0] v;
        case (idx)
            4'h0: rgb = 24'h000000;
            4'h1: rgb = 24'hfdfefc;
            4'h2: rgb = 24'hbe1a24;
            4'h3: rgb = 24'h30e6c6;
            4'h4: rgb = 24'hb41ae2;
            4'h5: rgb = 24'h1fd21e;
            4'h6: rgb = 24'h211bae;
            4'h7: rgb = 24'hdff60a;
            4'h8: rgb = 24'hb84104;
            4'h9: rgb = 24'h6a3304;
            4'ha: rgb = 24'hfe4a57;
            4'hb: rgb = 24'h424540;
            4'hc: rgb = 24'h70746f;
            4'hd: rgb = 24'h59fe59;
            4'he: rgb = 24'h5f53fe;
            default: rgb = 24'ha4a7a2;
        endcase
        v = ((rgb & 24'hf80000) >> 9) | ((rgb & 24'h00f800) >> 6) | ((rgb & 24'h0000ff) >> 3);
        return v[14:0];
    endfunction

    function automatic pix_t render_cell(input cell_t c, input cfg_t k);
        logic [14:0] lanes [8];
        logic [3:0]  idx;
        logic        bit_on;
        logic [1:0]  pair;
        logic        blank;
        for (int p = 0; p < 8; p++) begin
            bit_on = c.pattern[7-p];
            // multicolour pairs are two pixels wide, leftmost pair from bits 7:6
            pair   = {c.pattern[7-(p & 6)], c.pattern[6-(p & 6)]};
            blank  = 1'b0;
            idx    = 4'h0;
            if (c.border) begin
                idx = k.border_color;
            end
            else begin
                case (k.display_mode)
                    MODE_STD_TEXT: idx = bit_on ? c.color_nibble : k.bg_color[0];
                    MODE_MC_TEXT:
                    begin
                        if (c.color_nibble[3])
                            idx = (pair == 2'b11) ? {1'b0, c.color_nibble[2:0]}
                                                  : k.bg_color[pair];
                        else
                            idx = bit_on ? c.color_nibble : k.bg_color[0];
                    end
                    MODE_HIRES_BM: idx = bit_on ? c.char_code[7:4] : c.char_code[3:0];
                    MODE_MC_BM:
                    begin
                        case (pair)
                            2'b00:   idx = k.bg_color[0];
                            2'b01:   idx = c.char_code[7:4];
                            2'b10:   idx = c.char_code[3:0];
                            default: idx = c.color_nibble;
                        endcase
                    end
                    MODE_ECM_TEXT: idx = bit_on ? c.color_nibble : k.bg_color[c.char_code[7:6]];
                    default:       blank = 1'b1;
                endcase
            end
            lanes[p] = blank ? BLACK : palette_rgb555(idx);
        end
        return {lanes[0], lanes[1], lanes[2], lanes[3],
                lanes[4], lanes[5], lanes[6], lanes[7]};
    endfunction

    function automatic cfg_t mk_cfg(input logic [2:0] mode, input logic [3:0] brd,
                                    input logic [3:0] b0, input logic [3:0] b1,
                                    input logic [3:0] b2, input logic [3:0] b3);
        cfg_t k;
        k.display_mode = mode;
        k.border_color = brd;
        k.bg_color     = {b3, b2, b1, b0};
        return k;
    endfunction

    function automatic void add_row(input cfg_t k, input logic brd, input logic [7:0] code,
                                    input logic [7:0] pat, input logic [3:0] col,
                                    input bit known = 1'b0, input logic [14:0] fill = BLACK);
        row_t r;
        r.k              = k;
        r.c.border       = brd;
        r.c.char_code    = code;
        r.c.pattern      = pat;
        r.c.color_nibble = col;
        r.known          = known;
        r.fill           = fill;
        cell_table.push_back(r);
    endfunction

    // mostly back-to-back, some short gaps, a few long ones; none while no_idle is set
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic program_regs(input cfg_t k);
        apb_write(REG_DISPLAY_MODE, {29'd0, k.display_mode});
        apb_write(REG_BORDER_COLOR, {28'd0, k.border_color});
        apb_write(REG_BG_COLOR_0,   {28'd0, k.bg_color[0]});
        apb_write(REG_BG_COLOR_1,   {28'd0, k.bg_color[1]});
        apb_write(REG_BG_COLOR_2,   {28'd0, k.bg_color[2]});
        apb_write(REG_BG_COLOR_3,   {28'd0, k.bg_color[3]});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_cell(input cell_t c, input pix_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cell_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data  <= c;
        do
            @(posedge clk);
        while (!cell_ready);
        pixels_due.push_back(want);
    endtask

    // stop feeding and let every cell in flight come out
    task automatic settle();
        cell_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    initial begin
        int run;
        int gap;
        pix_ready = 1'b0;
        forever begin
            run = $urandom_range(1, 12);
            pix_ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                pix_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && pix_valid && pix_ready) begin
            if (pixels_due.size() == 0) begin
                flag_mismatch("pixel item with nothing expected");
            end
            else begin
                head = pixels_due.pop_front();
                for (lane = 0; lane < 8; lane++)
                    if (pixels[(7-lane)*15 +: 15] !== head[(7-lane)*15 +: 15])
                        flag_mismatch($sformatf("pixel_%0d got %h want %h", lane,
                                                pixels[(7-lane)*15 +: 15],
                                                head[(7-lane)*15 +: 15]));
            end
        end
    end

    always @(posedge clk) begin
        if ((cell_valid && cell_ready) || (pix_valid && pix_ready) || (psel && penable)) begin
            stalled_cycles <= 0;
        end
        else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        cfg_t        live_cfg;
        cfg_t        k;
        cell_t       c;
        pix_t        want;
        logic [2:0]  mode;
        int          items;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cell_valid = 1'b0;
        cell_data  = '0;

        k = mk_cfg(MODE_STD_TEXT, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b1, 8'hff, 8'hff, 4'hf, 1'b1, BLACK);
        k = mk_cfg(MODE_STD_TEXT, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b1, 8'h00, 8'h00, 4'h0, 1'b1, WHITE);
        k = mk_cfg(MODE_STD_TEXT, 4'h0, 4'h1, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b0, 8'hff, 8'h00, 4'hf, 1'b1, WHITE);
        k = mk_cfg(MODE_STD_TEXT, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b0, 8'h00, 8'hff, 4'hf, 1'b1, LIGHT_GREY);
        k = mk_cfg(MODE_STD_TEXT, 4'h0, 4'h6, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b0, 8'h3c, 8'ha5, 4'h2);
        // multicolour text: colour bit 3 set selects pairs, bit 3 clear falls back to standard text
        k = mk_cfg(MODE_MC_TEXT, 4'h0, 4'h6, 4'h2, 4'h5, 4'h9);
        add_row(k, 1'b0, 8'h11, 8'h3c, 4'h7);
        add_row(k, 1'b0, 8'h22, 8'h1b, 4'hf);
        add_row(k, 1'b0, 8'h33, 8'hff, 4'h8, 1'b1, BLACK);
        add_row(k, 1'b0, 8'h44, 8'he4, 4'hd);
        k = mk_cfg(MODE_HIRES_BM, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b0, 8'ha5, 8'hf0, 4'h3);
        add_row(k, 1'b0, 8'hf0, 8'hff, 4'h0, 1'b1, LIGHT_GREY);
        add_row(k, 1'b0, 8'h01, 8'h00, 4'hf, 1'b1, WHITE);
        k = mk_cfg(MODE_MC_BM, 4'h0, 4'h3, 4'h0, 4'h0, 4'h0);
        add_row(k, 1'b0, 8'h5a, 8'h1b, 4'h9);
        add_row(k, 1'b0, 8'h00, 8'hff, 4'hf, 1'b1, LIGHT_GREY);
        add_row(k, 1'b0, 8'hff, 8'h00, 4'h0);
        // extended background: char code bits 7:6 pick the background
        k = mk_cfg(MODE_ECM_TEXT, 4'h0, 4'h1, 4'h4, 4'h7, 4'hc);
        add_row(k, 1'b0, 8'h00, 8'h00, 4'he);
        add_row(k, 1'b0, 8'h40, 8'h3c, 4'he);
        add_row(k, 1'b0, 8'h80, 8'h00, 4'he);
        add_row(k, 1'b0, 8'hc0, 8'h3c, 4'he);
        add_row(k, 1'b0, 8'h3f, 8'hff, 4'h1, 1'b1, WHITE);
        k = mk_cfg(MODE_RSVD_5, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1);
        add_row(k, 1'b0, 8'hff, 8'hff, 4'hf, 1'b1, BLACK);
        k = mk_cfg(MODE_RSVD_6, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1);
        add_row(k, 1'b0, 8'hff, 8'hff, 4'hf, 1'b1, BLACK);
        // border wins even in an undefined mode
        k = mk_cfg(MODE_RSVD_7, 4'hf, 4'h1, 4'h1, 4'h1, 4'h1);
        add_row(k, 1'b1, 8'h00, 8'h00, 4'h0, 1'b1, LIGHT_GREY);
        k = mk_cfg(MODE_MC_BM, 4'h2, 4'h5, 4'h6, 4'h7, 4'h8);
        add_row(k, 1'b1, 8'h5a, 8'h1b, 4'h9);
        k = mk_cfg(MODE_ECM_TEXT, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf);
        add_row(k, 1'b0, 8'hff, 8'h55, 4'h0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        live_cfg = mk_cfg(MODE_STD_TEXT, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
        foreach (cell_table[i]) begin
            if (cell_table[i].k != live_cfg) begin
                settle();
                program_regs(cell_table[i].k);
                live_cfg = cell_table[i].k;
            end
            want = cell_table[i].known ? {8{cell_table[i].fill}}
                                       : render_cell(cell_table[i].c, live_cfg);
            send_cell(cell_table[i].c, want);
        end

        for (int ph = 0; ph < 12; ph++) begin
            settle();
            mode = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 4));
            case (ph % 4)
                1:       k = mk_cfg(mode, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf);
                3:       k = mk_cfg(mode, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
                default: k = mk_cfg(mode, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)));
            endcase
            program_regs(k);
            live_cfg = k;
            no_idle  = (ph % 5 == 2);
            items    = (mode > MODE_ECM_TEXT) ? 60 : 220;
            for (int n = 0; n < items; n++) begin
                c.border       = ($urandom_range(0, 7) == 0);
                c.char_code    = 8'($urandom_range(0, 255));
                c.color_nibble = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 19))
                    0:       c.pattern = 8'h00;
                    1:       c.pattern = 8'hff;
                    default: c.pattern = 8'($urandom_range(0, 255));
                endcase
                send_cell(c, render_cell(c, live_cfg));
            end
        end
        no_idle = 1'b0;

        settle();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (pixels_due.size() != 0)
            flag_mismatch($sformatf("%0d pixel items never arrived", pixels_due.size()));
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
